### sv/gf2_polynomial_alu_defines.svh
// assertion macros for the gf2 polynomial alu
// no dependencies; included by the files that check their own logic
`ifndef GF2_POLYNOMIAL_ALU_DEFINES_SVH
`define GF2_POLYNOMIAL_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define GPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gpa assertion failed");
`define GPA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gpa assertion failed");
`else
`define GPA_ASSERT(lbl, prop)
`define GPA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/gpa_pkg.sv
// constants, operation codes and the cell payload type of the gf2 polynomial alu
// no dependencies
package gpa_pkg;

    localparam int WIDTH    = 16;
    localparam int OPND_W   = 16;
    localparam int RESULT_W = 31;
    localparam int PROD_W   = 2 * WIDTH - 1;
    localparam int SHIFT_W  = $clog2(WIDTH);
    localparam int IDX_W    = $clog2(PROD_W);

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_ADD = 2'd0;
    localparam t_kind KIND_MUL = 2'd1;
    localparam t_kind KIND_QUO = 2'd2;
    localparam t_kind KIND_REM = 2'd3;

    typedef struct packed {
        t_kind              op;
        logic [WIDTH-1:0]   x;
        logic [WIDTH-1:0]   y;
        logic [PROD_W-1:0]  w;
        logic [SHIFT_W-1:0] shift;
        logic               dz;
    } t_stage;

endpackage

### sv/gpa_ifs.sv
// valid/ready channel interfaces of the gf2 polynomial alu
// depends on gpa_pkg
interface gpa_in_if import gpa_pkg::*; ;
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;

    modport source(output valid, kind, operand_a, operand_b, input ready);
    modport sink(input valid, kind, operand_a, operand_b, output ready);
endinterface

interface gpa_out_if import gpa_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result;
    logic                divide_by_zero;

    modport source(output valid, result, divide_by_zero, input ready);
    modport sink(input valid, result, divide_by_zero, output ready);
endinterface

### sv/gpa_prep.sv
// entry logic: masks operands, forms the add result, finds divisor degree and normalizes divisor and dividend
// depends on gpa_pkg
module gpa_prep import gpa_pkg::*; (
    input  t_kind             i_kind,
    input  logic [OPND_W-1:0] i_operand_a,
    input  logic [OPND_W-1:0] i_operand_b,
    output t_stage            o_stage
);

    logic [WIDTH-1:0]   a;
    logic [WIDTH-1:0]   b;
    logic [SHIFT_W-1:0] deg;
    logic [SHIFT_W-1:0] shift;
    logic               b_zero;

    assign a      = i_operand_a[WIDTH-1:0];
    assign b      = i_operand_b[WIDTH-1:0];
    assign b_zero = (b == '0);

    always_comb begin
        deg = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (b[i]) begin
                deg = SHIFT_W'(i);
            end
        end
    end

    assign shift = b_zero ? '0 : (SHIFT_W'(WIDTH - 1) - deg);

    always_comb begin
        o_stage    = '0;
        o_stage.op = i_kind;
        case (i_kind)
            KIND_ADD: begin
                o_stage.w = PROD_W'(a ^ b);
            end
            KIND_MUL: begin
                o_stage.x = a;
                o_stage.y = b;
            end
            KIND_QUO, KIND_REM: begin
                o_stage.x     = b << shift;
                o_stage.w     = PROD_W'(a) << shift;
                o_stage.shift = shift;
                o_stage.dz    = b_zero;
            end
            default: begin
                o_stage.w = '0;
            end
        endcase
    end

endmodule

### sv/gpa_cell.sv
// one cell of the chain: one shift-and-xor step of multiply or long division
// depends on gpa_pkg
module gpa_cell import gpa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SHIFT_W-1:0] i_step,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_stage             i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output t_stage             o_data
);

    logic              r_valid;
    t_stage            r_data;
    t_stage            n_data;
    logic [IDX_W-1:0]  hi_idx;
    logic [PROD_W-1:0] x_shifted;

    assign hi_idx    = IDX_W'(WIDTH - 1) + IDX_W'(i_step);
    assign x_shifted = PROD_W'(i_data.x) << i_step;

    always_comb begin
        n_data = i_data;
        if (i_data.op == KIND_MUL) begin
            if (i_data.y[i_step]) begin
                n_data.w = i_data.w ^ x_shifted;
            end
        end else if ((i_data.op inside {KIND_QUO, KIND_REM}) && !i_data.dz
                     && i_data.w[hi_idx]) begin
            n_data.w         = i_data.w ^ x_shifted;
            n_data.y[i_step] = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/gpa_finish.sv
// result selection, remainder denormalization and output register
// depends on gpa_pkg, gpa_ifs and gf2_polynomial_alu_defines.svh
`include "gf2_polynomial_alu_defines.svh"
module gpa_finish import gpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_stage     i_data,
    gpa_out_if.source  o_out
);

    logic                r_valid;
    logic [RESULT_W-1:0] r_result;
    logic                r_dz;
    logic [PROD_W-1:0]   n_result;

    always_comb begin
        case (i_data.op)
            KIND_QUO: n_result = i_data.dz ? '0 : PROD_W'(i_data.y);
            KIND_REM: n_result = i_data.w >> i_data.shift;
            default:  n_result = i_data.w;
        endcase
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= RESULT_W'(n_result);
            r_dz     <= i_data.dz;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.result         = r_result;
    assign o_out.divide_by_zero = r_dz;

    // flag only on division kinds
    `GPA_ASSERT(a_dz_div_only, i_valid && i_data.dz |-> (i_data.op == KIND_QUO || i_data.op == KIND_REM))
    // no normalization shift outside division
    `GPA_ASSERT(a_shift_div_only, i_valid && (i_data.op == KIND_ADD || i_data.op == KIND_MUL) |-> i_data.shift == '0)
    // division leaves the remainder below the divisor degree
    `GPA_ASSERT(a_rem_reduced, i_valid && !i_data.dz && (i_data.op == KIND_QUO || i_data.op == KIND_REM) |-> i_data.w[PROD_W-1:WIDTH-1] == '0)
    // output register holds a beat while stalled
    `GPA_ASSERT_ALWAYS(a_hold_on_stall, i_rst_n && $past(i_rst_n) && $past(r_valid && !o_out.ready) |-> r_valid && $stable(r_result))

endmodule

### sv/gf2_polynomial_alu.sv
// top level of the gf2 polynomial alu: entry logic, chain of step cells, output stage
// depends on gpa_pkg, gpa_ifs, gpa_prep, gpa_cell and gpa_finish
//
// usage:
//   i_in carries one beat per operation: kind (add, multiply, quotient,
//   remainder) and two 16-bit polynomials, bit i the coefficient of x^i.
//   o_out returns one beat per input beat, in order: a 31-bit result and a
//   divide_by_zero flag, set for quotient or remainder with a zero divisor
//   (quotient 0, remainder equal to the dividend).
//   from the accepting edge to o_out.valid a beat passes one register
//   in each of the 16 step cells and one in the output stage.
//   throughput is one beat per cycle while o_out is not stalled; each cell does one shift-and-xor step,
//   so the rate is set by the cell register handoff.
//   each stage holds its beat while the next one is full and stalled, so
//   bubbles collapse and i_in.ready stays high until all 17 stages are full.
//   a stalled o_out holds its beat stable.
//   reset (synchronous, active low) empties every stage; there is no other
//   state.
module gf2_polynomial_alu import gpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpa_in_if.sink    i_in,
    gpa_out_if.source o_out
);

    logic   stage_valid [WIDTH+1];
    logic   stage_ready [WIDTH+1];
    t_stage stage_data  [WIDTH+1];

    gpa_prep u_prep (
        .i_kind      (i_in.kind),
        .i_operand_a (i_in.operand_a),
        .i_operand_b (i_in.operand_b),
        .o_stage     (stage_data[0])
    );

    assign stage_valid[0] = i_in.valid;
    assign i_in.ready     = stage_ready[0];

    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        gpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (SHIFT_W'(WIDTH - 1 - k)),
            .i_valid (stage_valid[k]),
            .o_ready (stage_ready[k]),
            .i_data  (stage_data[k]),
            .o_valid (stage_valid[k+1]),
            .i_ready (stage_ready[k+1]),
            .o_data  (stage_data[k+1])
        );
    end

    gpa_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[WIDTH]),
        .o_ready (stage_ready[WIDTH]),
        .i_data  (stage_data[WIDTH]),
        .o_out   (o_out)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of gf2_polynomial_alu: directed and random operations with checking
// depends on gpa_pkg, gpa_ifs and the gf2_polynomial_alu rtl
module testbench;
    import gpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int HOLDOFF_CYCLES = 80;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                dz;
    } t_answer;

    typedef struct packed {
        t_kind             kind;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic              drain;
    } t_operation;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpa_in_if  in_ch();
    gpa_out_if out_ch();

    gf2_polynomial_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_operation pending_ops[$];
    t_answer    expected_answers[$];

    int mismatch_cnt = 0;
    int accepted_cnt = 0;
    int returned_cnt = 0;
    int sent_cnt     = 0;
    int total_ops    = 0;

    always #10 i_clk = ~i_clk;

    // addition, carry-less multiply and polynomial long division over gf2
    function automatic t_answer gf2_evaluate(t_kind op, logic [OPND_W-1:0] a_in,
                                             logic [OPND_W-1:0] b_in);
        t_answer          ans;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [PROD_W-1:0] acc;
        logic [PROD_W-1:0] rem;
        logic [WIDTH-1:0] quo;
        int               degb;
        a      = a_in[WIDTH-1:0];
        b      = b_in[WIDTH-1:0];
        acc    = '0;
        ans.dz = 1'b0;
        case (op)
            KIND_ADD: begin
                acc = PROD_W'(a ^ b);
            end
            KIND_MUL: begin
                for (int i = 0; i < WIDTH; i++)
                    if (b[i]) acc ^= PROD_W'(a) << i;
            end
            default: begin
                if (b == '0) begin
                    ans.dz = 1'b1;
                    acc    = (op == KIND_QUO) ? '0 : PROD_W'(a);
                end else begin
                    degb = 0;
                    for (int i = 0; i < WIDTH; i++)
                        if (b[i]) degb = i;
                    rem = PROD_W'(a);
                    quo = '0;
                    for (int i = WIDTH - 1; i >= degb; i--) begin
                        if (rem[i]) begin
                            rem ^= PROD_W'(b) << (i - degb);
                            quo[i - degb] = 1'b1;
                        end
                    end
                    acc = (op == KIND_QUO) ? PROD_W'(quo) : rem;
                end
            end
        endcase
        ans.result = RESULT_W'(acc);
        return ans;
    endfunction

    function automatic logic [OPND_W-1:0] random_poly(bit divisor);
        logic [OPND_W-1:0] v;
        int                pick;
        pick = $urandom_range(0, 19);
        v    = OPND_W'($urandom);
        if (divisor && pick == 0)
            v = '0;
        else if (divisor && pick == 1)
            v = OPND_W'(1);
        else if (pick < 3)
            v = (pick == 2) ? '1 : '0;
        else if (pick < 6)
            v = OPND_W'(1) << $urandom_range(0, OPND_W - 1);
        else if (pick < 11)
            v = v & ((OPND_W'(1) << $urandom_range(1, OPND_W - 1)) - 1'b1);
        return v;
    endfunction

    task automatic queue_op(t_kind k, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b, logic drain);
        t_operation op;
        op.kind  = k;
        op.a     = a;
        op.b     = b;
        op.drain = drain;
        pending_ops.push_back(op);
    endtask

    task automatic report_mismatch(string field, logic [RESULT_W-1:0] got,
                                   logic [RESULT_W-1:0] want);
        $display("mismatch on %0s at result beat %0d: got %h want %h",
                 field, returned_cnt, got, want);
        mismatch_cnt++;
    endtask

    // sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    t_operation next_op;
    logic       drv_valid;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(in_ch.valid && accepted_cnt != sent_cnt)) begin
                drv_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain && expected_answers.size() != 0)) begin
                    next_op   = pending_ops.pop_front();
                    drv_valid = 1'b1;
                    sent_cnt++;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left = $urandom_range(150, 300);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 30);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                    in_ch.kind      <= next_op.kind;
                    in_ch.operand_a <= next_op.a;
                    in_ch.operand_b <= next_op.b;
                end
                in_ch.valid <= drv_valid;
            end
        end
    end

    // receiver: stall modes of its own plus long hold-offs
    int   holdoff_left  = 0;
    int   holdoff_stage = 0;
    int   mode          = 0;
    int   mode_left     = 0;
    int   phase         = 0;
    logic rcv_ready;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left--;
                rcv_ready = 1'b0;
            end else if ((holdoff_stage == 0 && accepted_cnt >= 300) ||
                         (holdoff_stage == 1 && accepted_cnt >= 900)) begin
                holdoff_stage++;
                holdoff_left = HOLDOFF_CYCLES - 1;
                rcv_ready    = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       rcv_ready = 1'b1;
                    1:       rcv_ready = ($urandom_range(0, 3) != 0);
                    default: rcv_ready = (phase % 7) > 2;
                endcase
            end
            out_ch.ready <= rcv_ready;
        end
    end

    // beat bookkeeping and result check
    t_answer want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected beat", out_ch.result, '0);
                end else begin
                    want = expected_answers.pop_front();
                    if (out_ch.result !== want.result)
                        report_mismatch("result", out_ch.result, want.result);
                    if (out_ch.divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", RESULT_W'(out_ch.divide_by_zero),
                                        RESULT_W'(want.dz));
                end
                returned_cnt++;
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_answers.push_back(gf2_evaluate(in_ch.kind, in_ch.operand_a,
                                                        in_ch.operand_b));
                accepted_cnt++;
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;

        queue_op(KIND_ADD, 16'h0000, 16'h0000, 1'b0);
        queue_op(KIND_ADD, 16'hffff, 16'hffff, 1'b0);
        queue_op(KIND_ADD, 16'hffff, 16'h0000, 1'b0);
        queue_op(KIND_ADD, 16'haaaa, 16'h5555, 1'b0);
        queue_op(KIND_MUL, 16'h0000, 16'hffff, 1'b0);
        queue_op(KIND_MUL, 16'hffff, 16'hffff, 1'b0);
        queue_op(KIND_MUL, 16'h8000, 16'h8000, 1'b0);
        queue_op(KIND_MUL, 16'h0001, 16'hffff, 1'b0);
        queue_op(KIND_MUL, 16'hffff, 16'h0001, 1'b0);
        queue_op(KIND_QUO, 16'hffff, 16'h0000, 1'b0);
        queue_op(KIND_REM, 16'hffff, 16'h0000, 1'b0);
        queue_op(KIND_QUO, 16'h0000, 16'h0000, 1'b0);
        queue_op(KIND_REM, 16'h1234, 16'h0000, 1'b0);
        queue_op(KIND_QUO, 16'hffff, 16'h0001, 1'b0);
        queue_op(KIND_REM, 16'hffff, 16'h0001, 1'b0);
        queue_op(KIND_QUO, 16'hffff, 16'hffff, 1'b0);
        queue_op(KIND_REM, 16'hffff, 16'hffff, 1'b0);
        queue_op(KIND_QUO, 16'h0000, 16'h8000, 1'b0);
        queue_op(KIND_REM, 16'h7fff, 16'h8000, 1'b0);
        queue_op(KIND_QUO, 16'hffff, 16'h8000, 1'b0);
        queue_op(KIND_QUO, 16'h1234, 16'h0003, 1'b0);
        queue_op(KIND_REM, 16'h1234, 16'h0003, 1'b0);
        queue_op(KIND_REM, 16'h0000, 16'h0001, 1'b0);
        queue_op(KIND_MUL, 16'h00ff, 16'hff00, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            t_kind k;
            k = t_kind'($urandom_range(0, 3));
            queue_op(k, random_poly(1'b0), random_poly(k == KIND_QUO || k == KIND_REM),
                     (n == RANDOM_ITEMS / 2));
        end
        total_ops = pending_ops.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_cnt == total_ops);
        wait (expected_answers.size() == 0);
        repeat (40) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
